### rtl/core/hrbm_pkg.sv
// Shared types, codes and the division step for the hash range bucket mapper.
`timescale 1ns / 1ps

package hrbm_pkg;

  localparam int unsigned DIV_STEPS = 16;
  localparam int unsigned CFG_DIV_BITS = 33;

  localparam logic [15:0] RST_MAX_PAR = 16'd128;
  localparam logic [14:0] RST_FIRST_GROUP = 15'd0;
  localparam logic [14:0] RST_LAST_GROUP = 15'd127;
  localparam logic [16:0] RST_BUCKET_COUNT = 17'd1;
  localparam logic [15:0] MAX_GROUPS = 16'd32768;
  localparam logic [16:0] MAX_BUCKETS = 17'd65536;
  localparam logic [32:0] HASH_TOTAL = 33'h1_0000_0000;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_CFG   = 2'd1,
    ST_SPAN_LOW  = 2'd2,
    ST_OUT_RANGE = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CMD_MAP    = 2'd0,
    CMD_BUCKET = 2'd1,
    CMD_TASK   = 2'd2,
    CMD_RSVD   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    REG_MAX_PAR      = 2'd0,
    REG_FIRST_GROUP  = 2'd1,
    REG_LAST_GROUP   = 2'd2,
    REG_BUCKET_COUNT = 2'd3
  } reg_idx_e;

  typedef enum logic [2:0] {
    CFG_IDLE,
    CFG_CHECK,
    CFG_DIV_BASE,
    CFG_GROUP,
    CFG_SPAN,
    CFG_DIV_SPAN
  } cfg_state_e;

  typedef struct packed {
    logic        idle;
    logic [1:0]  status;
    logic [31:0] first;
    logic [31:0] last;
    logic [32:0] span;
    logic [16:0] bc;
    logic [32:0] s;
    logic [15:0] r;
  } cfg_state_t;

  typedef struct packed {
    logic [32:0] rem;
    logic [15:0] nq;
  } lane_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  cmd;
    lane_t       lane_a;
    lane_t       lane_b;
    lane_t       lane_c;
    logic [32:0] qs;
    logic [32:0] q1s;
  } cell_t;

  // One restoring division step: shift in the next dividend bit, subtract if it fits.
  function automatic lane_t lane_step(lane_t l, logic [32:0] d);
    logic [33:0] trial;
    lane_t       r;
    trial = {l.rem, l.nq[15]} - {1'b0, d};
    if (!trial[33]) begin
      r.rem = trial[32:0];
    end else begin
      r.rem = {l.rem[31:0], l.nq[15]};
    end
    r.nq = {l.nq[14:0], ~trial[33]};
    return r;
  endfunction

endpackage

### rtl/core/hrbm_if.sv
// Valid/ready channel interfaces for queries and results.
`timescale 1ns / 1ps

interface hrbm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [31:0] query_value;

  modport source (output valid, output command, output query_value, input ready);
  modport sink (input valid, input command, input query_value, output ready);
endinterface

interface hrbm_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] bucket_index;
  logic [31:0] range_start;
  logic [31:0] range_end;

  modport source (output valid, output status, output bucket_index, output range_start,
                  output range_end, input ready);
  modport sink (input valid, input status, input bucket_index, input range_start,
                input range_end, output ready);
endinterface

### rtl/core/hrbm_cfg.sv
// Configuration registers and the sequencer that derives the task hash range.
`timescale 1ns / 1ps

module hrbm_cfg (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [1:0]             cfg_idx_i,
  input  logic [16:0]            cfg_data_i,
  output hrbm_pkg::cfg_state_t   cfg_o
);

  hrbm_pkg::cfg_state_e state_q, state_d;

  logic [15:0] mp_q;
  logic [14:0] fg_q;
  logic [14:0] lg_q;
  logic [16:0] bc_q;
  logic [5:0]  cnt_q;
  logic [32:0] dq_q;
  logic [16:0] rem_q;
  logic [16:0] div_q;
  logic [32:0] base_q;
  logic [15:0] extra_q;
  logic [31:0] first_q;
  logic [32:0] lastp_q;
  logic [31:0] last_q;
  logic [32:0] span_q;
  logic [32:0] s_q;
  logic [15:0] r_q;
  logic [1:0]  status_q;

  logic        cfg_bad;
  logic        busy;
  logic        div_run;
  logic        div_last;
  logic [17:0] trial;
  logic [16:0] rem_next;
  logic [32:0] dq_next;
  logic [32:0] span_d;
  logic        span_low;
  logic [15:0] lg1;
  logic [15:0] min_first;
  logic [15:0] min_last;

  assign cfg_bad = (mp_q == 16'd0) || (mp_q > hrbm_pkg::MAX_GROUPS) || (fg_q > lg_q) ||
                   ({1'b0, lg_q} >= mp_q) || (bc_q == 17'd0) ||
                   (bc_q > hrbm_pkg::MAX_BUCKETS);

  assign trial    = {rem_q, dq_q[32]} - {1'b0, div_q};
  assign rem_next = trial[17] ? {rem_q[15:0], dq_q[32]} : trial[16:0];
  assign dq_next  = {dq_q[31:0], ~trial[17]};

  assign span_d   = lastp_q - {1'b0, first_q};
  assign span_low = span_d < {16'd0, bc_q};

  assign lg1       = {1'b0, lg_q} + 16'd1;
  assign min_first = ({1'b0, fg_q} < extra_q) ? {1'b0, fg_q} : extra_q;
  assign min_last  = (lg1 < extra_q) ? lg1 : extra_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      hrbm_pkg::CFG_IDLE:     state_d = hrbm_pkg::CFG_IDLE;
      hrbm_pkg::CFG_CHECK:    state_d = cfg_bad ? hrbm_pkg::CFG_IDLE : hrbm_pkg::CFG_DIV_BASE;
      hrbm_pkg::CFG_DIV_BASE: state_d = div_last ? hrbm_pkg::CFG_GROUP : hrbm_pkg::CFG_DIV_BASE;
      hrbm_pkg::CFG_GROUP:    state_d = hrbm_pkg::CFG_SPAN;
      hrbm_pkg::CFG_SPAN:     state_d = span_low ? hrbm_pkg::CFG_IDLE : hrbm_pkg::CFG_DIV_SPAN;
      hrbm_pkg::CFG_DIV_SPAN: state_d = div_last ? hrbm_pkg::CFG_IDLE : hrbm_pkg::CFG_DIV_SPAN;
      default:                state_d = hrbm_pkg::CFG_IDLE;
    endcase
    if (cfg_we_i) begin
      state_d = hrbm_pkg::CFG_CHECK;
    end
  end

  always_comb begin
    busy     = 1'b1;
    div_run  = 1'b0;
    case (state_q)
      hrbm_pkg::CFG_IDLE:     busy = 1'b0;
      hrbm_pkg::CFG_DIV_BASE: div_run = 1'b1;
      hrbm_pkg::CFG_DIV_SPAN: div_run = 1'b1;
      default:                busy = 1'b1;
    endcase
    div_last = div_run && (cnt_q == 6'(hrbm_pkg::CFG_DIV_BITS - 1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= hrbm_pkg::CFG_IDLE;
      mp_q     <= hrbm_pkg::RST_MAX_PAR;
      fg_q     <= hrbm_pkg::RST_FIRST_GROUP;
      lg_q     <= hrbm_pkg::RST_LAST_GROUP;
      bc_q     <= hrbm_pkg::RST_BUCKET_COUNT;
      first_q  <= 32'd0;
      last_q   <= 32'hFFFF_FFFF;
      span_q   <= hrbm_pkg::HASH_TOTAL;
      s_q      <= hrbm_pkg::HASH_TOTAL;
      r_q      <= 16'd0;
      status_q <= hrbm_pkg::ST_OK;
      cnt_q    <= 6'd0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          hrbm_pkg::REG_MAX_PAR:      mp_q <= cfg_data_i[15:0];
          hrbm_pkg::REG_FIRST_GROUP:  fg_q <= cfg_data_i[14:0];
          hrbm_pkg::REG_LAST_GROUP:   lg_q <= cfg_data_i[14:0];
          hrbm_pkg::REG_BUCKET_COUNT: bc_q <= cfg_data_i;
          default:                    bc_q <= bc_q;
        endcase
      end
      if (div_run) begin
        cnt_q <= cnt_q + 6'd1;
      end else begin
        cnt_q <= 6'd0;
      end
      case (state_q)
        hrbm_pkg::CFG_CHECK: begin
          if (cfg_bad) begin
            status_q <= hrbm_pkg::ST_BAD_CFG;
            first_q  <= 32'd0;
            last_q   <= 32'd0;
            span_q   <= 33'd0;
          end
        end
        hrbm_pkg::CFG_GROUP: begin
          first_q <= 32'(fg_q * base_q + {17'd0, min_first});
        end
        hrbm_pkg::CFG_SPAN: begin
          span_q <= span_d;
          last_q <= 32'(lastp_q - 33'd1);
          if (span_low) begin
            status_q <= hrbm_pkg::ST_SPAN_LOW;
          end
        end
        hrbm_pkg::CFG_DIV_SPAN: begin
          if (div_last) begin
            status_q <= hrbm_pkg::ST_OK;
            s_q      <= dq_next;
            r_q      <= rem_next[15:0];
          end
        end
        default: begin
          status_q <= status_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      hrbm_pkg::CFG_CHECK: begin
        dq_q  <= hrbm_pkg::HASH_TOTAL;
        rem_q <= 17'd0;
        div_q <= {1'b0, mp_q};
      end
      hrbm_pkg::CFG_DIV_BASE: begin
        dq_q  <= dq_next;
        rem_q <= rem_next;
        if (div_last) begin
          base_q  <= dq_next;
          extra_q <= rem_next[15:0];
        end
      end
      hrbm_pkg::CFG_GROUP: begin
        lastp_q <= 33'(lg1 * base_q + {17'd0, min_last});
      end
      hrbm_pkg::CFG_SPAN: begin
        dq_q  <= span_d;
        rem_q <= 17'd0;
        div_q <= bc_q;
      end
      hrbm_pkg::CFG_DIV_SPAN: begin
        dq_q  <= dq_next;
        rem_q <= rem_next;
      end
      default: begin
        div_q <= div_q;
      end
    endcase
  end

  assign cfg_o.idle   = ~busy;
  assign cfg_o.status = status_q;
  assign cfg_o.first  = first_q;
  assign cfg_o.last   = last_q;
  assign cfg_o.span   = span_q;
  assign cfg_o.bc     = bc_q;
  assign cfg_o.s      = s_q;
  assign cfg_o.r      = r_q;

endmodule

### rtl/core/hrbm_cell.sv
// One divider cell: a restoring step on each of the three lanes, with a handshake stage.
`timescale 1ns / 1ps

module hrbm_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [32:0]         span_i,
  input  logic [16:0]         bc_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  hrbm_pkg::cell_t     in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output hrbm_pkg::cell_t     out_data_o
);

  logic            valid_q;
  hrbm_pkg::cell_t data_q, data_d;

  always_comb begin
    data_d        = in_data_i;
    data_d.lane_a = hrbm_pkg::lane_step(in_data_i.lane_a, span_i);
    data_d.lane_b = hrbm_pkg::lane_step(in_data_i.lane_b, {16'd0, bc_i});
    data_d.lane_c = hrbm_pkg::lane_step(in_data_i.lane_c, {16'd0, bc_i});
  end

  assign in_ready_o = ~valid_q | out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

### rtl/core/hash_range_bucket_mapper_top.sv
// Top level: query preparation, chain of divider cells and result register.
// An item goes from acceptance to its result through one preparation stage, sixteen
// divider cells (one quotient bit each) and the result register. The cell chain holds
// up to 16 items in flight; one item is accepted per cycle unless stalled or cfg is busy.
// After reset the block is ready at once with the default configuration derived.
// After a register write the sequencer derives the range anew in up to two 33-step divisions.
`timescale 1ns / 1ps

module hash_range_bucket_mapper_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  hrbm_in_if.sink            in_if,
  hrbm_out_if.source         out_if,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [16:0]        cfg_data_i
);

  localparam int unsigned NCELL = hrbm_pkg::DIV_STEPS;

  hrbm_pkg::cfg_state_t cfg;

  logic            pipe_v   [NCELL+1];
  logic            pipe_rdy [NCELL+1];
  hrbm_pkg::cell_t pipe_d   [NCELL+1];

  logic            prep_v_q;
  hrbm_pkg::cell_t prep_q, prep_d;
  logic            prep_rdy;

  logic [31:0] q;
  logic [31:0] off;
  logic [15:0] qb;
  logic [16:0] q1;
  logic [48:0] num_a;
  logic [32:0] num_b;
  logic [32:0] num_c;
  logic [1:0]  status_d;

  logic        out_v_q;
  logic [1:0]  out_status_q;
  logic [15:0] out_bidx_q;
  logic [31:0] out_rs_q;
  logic [31:0] out_re_q;
  logic [1:0]  fin_status;
  logic [15:0] fin_bidx;
  logic [31:0] fin_rs;
  logic [31:0] fin_re;
  hrbm_pkg::cell_t fin;

  hrbm_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  assign q     = in_if.query_value;
  assign off   = q - cfg.first;
  assign qb    = q[15:0];
  assign q1    = {1'b0, qb} + 17'd1;
  assign num_a = off * cfg.bc;
  assign num_b = qb * cfg.r + {16'd0, cfg.bc} - 33'd1;
  assign num_c = q1 * cfg.r + {16'd0, cfg.bc} - 33'd1;

  always_comb begin
    status_d = hrbm_pkg::ST_OK;
    if (cfg.status != hrbm_pkg::ST_OK) begin
      status_d = cfg.status;
    end else begin
      case (in_if.command)
        hrbm_pkg::CMD_MAP: begin
          if (q < cfg.first || q > cfg.last) begin
            status_d = hrbm_pkg::ST_OUT_RANGE;
          end
        end
        hrbm_pkg::CMD_BUCKET: begin
          if (q >= {15'd0, cfg.bc}) begin
            status_d = hrbm_pkg::ST_OUT_RANGE;
          end
        end
        hrbm_pkg::CMD_TASK: status_d = hrbm_pkg::ST_OK;
        default:            status_d = hrbm_pkg::ST_OUT_RANGE;
      endcase
    end
  end

  always_comb begin
    prep_d.status     = status_d;
    prep_d.cmd        = in_if.command;
    prep_d.lane_a.rem = num_a[48:16];
    prep_d.lane_a.nq  = num_a[15:0];
    prep_d.lane_b.rem = {16'd0, num_b[32:16]};
    prep_d.lane_b.nq  = num_b[15:0];
    prep_d.lane_c.rem = {16'd0, num_c[32:16]};
    prep_d.lane_c.nq  = num_c[15:0];
    prep_d.qs         = 33'(qb * cfg.s);
    prep_d.q1s        = 33'(q1 * cfg.s);
  end

  assign prep_rdy    = ~prep_v_q | pipe_rdy[0];
  assign in_if.ready = prep_rdy & cfg.idle & ~cfg_we_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prep_v_q <= 1'b0;
    end else if (prep_rdy) begin
      prep_v_q <= in_if.valid & in_if.ready;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) begin
      prep_q <= prep_d;
    end
  end

  assign pipe_v[0] = prep_v_q;
  assign pipe_d[0] = prep_q;

  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    hrbm_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .span_i      (cfg.span),
      .bc_i        (cfg.bc),
      .in_valid_i  (pipe_v[k]),
      .in_ready_o  (pipe_rdy[k]),
      .in_data_i   (pipe_d[k]),
      .out_valid_o (pipe_v[k+1]),
      .out_ready_i (pipe_rdy[k+1]),
      .out_data_o  (pipe_d[k+1])
    );
  end

  assign pipe_rdy[NCELL] = ~out_v_q | out_if.ready;
  assign fin             = pipe_d[NCELL];

  always_comb begin
    fin_status = fin.status;
    fin_bidx   = 16'd0;
    fin_rs     = 32'd0;
    fin_re     = 32'd0;
    if (fin.status == hrbm_pkg::ST_OK) begin
      case (fin.cmd)
        hrbm_pkg::CMD_MAP: fin_bidx = fin.lane_a.nq;
        hrbm_pkg::CMD_BUCKET: begin
          fin_rs = cfg.first + fin.qs[31:0] + {16'd0, fin.lane_b.nq};
          fin_re = cfg.first + fin.q1s[31:0] + {16'd0, fin.lane_c.nq} - 32'd1;
        end
        hrbm_pkg::CMD_TASK: begin
          fin_rs = cfg.first;
          fin_re = cfg.last;
        end
        default: fin_bidx = 16'd0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (pipe_rdy[NCELL]) begin
      out_v_q <= pipe_v[NCELL];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_rdy[NCELL] && pipe_v[NCELL]) begin
      out_status_q <= fin_status;
      out_bidx_q   <= fin_bidx;
      out_rs_q     <= fin_rs;
      out_re_q     <= fin_re;
    end
  end

  assign out_if.valid        = out_v_q;
  assign out_if.status       = out_status_q;
  assign out_if.bucket_index = out_bidx_q;
  assign out_if.range_start  = out_rs_q;
  assign out_if.range_end    = out_re_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_if.valid && in_if.ready) |-> cfg.idle)
    else $error("Item accepted while the configuration is being derived.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && out_if.status != hrbm_pkg::ST_OK) |->
    (out_if.bucket_index == 16'd0 && out_if.range_start == 32'd0 &&
     out_if.range_end == 32'd0))
    else $error("Error result carries nonzero fields.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> (out_if.range_start <= out_if.range_end))
    else $error("Result range starts after it ends.");

endmodule
